### rtl/core/sky_model_spline_evaluator_top_macros.svh
// Assertion macros used by the sky model spline evaluator top level.
`ifndef SKY_MODEL_SPLINE_EVALUATOR_TOP_MACROS_SVH
`define SKY_MODEL_SPLINE_EVALUATOR_TOP_MACROS_SVH
// Same-cycle implication, clocked on clk, off during reset.
`define SMSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, clocked on clk, off during reset.
`define SMSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/core/smse_pkg.sv
// Package: constants, types and helpers of the sky model spline evaluator.
`default_nettype none
package smse_pkg;
  localparam int TABLE_DEPTH  = 8192;
  localparam int TURB_STEPS   = 10;
  localparam int SHAPE_PARAMS = 9;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int RA_W         = ADDR_W + 2;
  localparam int CH_WORDS     = (SHAPE_PARAMS + 1) * 12 * TURB_STEPS;
  localparam int RAD_OFS      = SHAPE_PARAMS * 12 * TURB_STEPS;
  localparam int SET_OFS      = 6 * TURB_STEPS;
  localparam int TI_W         = $clog2(TURB_STEPS + 1);
  localparam int ROW_W        = $clog2(SHAPE_PARAMS + 1);

  localparam int IN_W   = 104;
  localparam int OUT_W  = 32;
  localparam int X_W    = 17;
  localparam int BAS_W  = 20;
  localparam int PRD_W  = 53;
  localparam int ACC_W  = 56;
  localparam int CUR_W  = 40;
  localparam int MP_W   = 58;
  localparam int MIX_W  = 43;
  localparam int TF_W   = 18;
  localparam int TP_W   = 61;

  localparam logic [15:0]    HALF_PI_Q14 = 16'd25736;
  localparam logic [X_W-1:0] ONE_Q16     = 17'd65536;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CBRT, ST_POW, ST_BAS, ST_MAC, ST_DRAIN,
    ST_MA0, ST_MA1, ST_MA2, ST_MA3, ST_MA4, ST_TB0, ST_TB1, ST_TB2
  } smse_state_t;

  typedef enum logic [1:0] {CB_IDLE, CB_SQ, CB_CU, CB_CMP} smse_cb_state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] elev;
  } smse_cb_req_t;

  typedef struct packed {
    logic           done;
    logic [X_W-1:0] x;
  } smse_cb_rsp_t;

  function automatic logic [3:0] binom5(input logic [2:0] k);
    case (k)
      3'd0: binom5 = 4'd1;
      3'd1: binom5 = 4'd5;
      3'd2: binom5 = 4'd10;
      3'd3: binom5 = 4'd10;
      3'd4: binom5 = 4'd5;
      3'd5: binom5 = 4'd1;
      default: binom5 = 4'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

### rtl/core/smse_cbrt.sv
// Bit-serial cube root of elevation over half pi, one bit per pass through the square, cube and compare states.
`default_nettype none
module smse_cbrt (
  input  logic                  clk,
  input  logic                  rst_n,
  input  smse_pkg::smse_cb_req_t req,
  output smse_pkg::smse_cb_rsp_t rsp
);
  import smse_pkg::*;

  smse_cb_state_t st_r, st_nxt;
  logic [15:0] x_r, x_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [15:0] elev_r, elev_nxt;
  logic        done_r, done_nxt;
  logic        sat_r, sat_nxt;
  logic [31:0] sq_r;
  logic [47:0] cu_r;
  logic [15:0] tr;
  logic [62:0] lhs;
  logic [63:0] rhs;

  assign tr  = x_r | (16'd1 << bit_r);
  // trial^3 <= floor(e*2^48/D)  <=>  trial^3 * D <= e*2^48
  assign lhs = 63'(cu_r) * 63'(HALF_PI_Q14);
  assign rhs = {elev_r, 48'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= CB_IDLE;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
      bit_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      sat_r  <= sat_nxt;
      bit_r  <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    elev_r <= elev_nxt;
    sq_r   <= 32'(tr) * 32'(tr);
    cu_r   <= 48'(sq_r) * 48'(tr);
  end

  always_comb begin
    st_nxt   = st_r;
    x_nxt    = x_r;
    bit_nxt  = bit_r;
    elev_nxt = elev_r;
    done_nxt = 1'b0;
    sat_nxt  = sat_r;
    case (st_r)
      CB_IDLE: begin
        if (req.start) begin
          elev_nxt = req.elev;
          x_nxt    = '0;
          bit_nxt  = 4'd15;
          if (req.elev >= HALF_PI_Q14) begin
            sat_nxt  = 1'b1;
            done_nxt = 1'b1;
          end else begin
            sat_nxt = 1'b0;
            st_nxt  = CB_SQ;
          end
        end
      end
      CB_SQ: st_nxt = CB_CU;
      CB_CU: st_nxt = CB_CMP;
      CB_CMP: begin
        if ({1'b0, lhs} <= rhs) x_nxt = tr;
        if (bit_r == 4'd0) begin
          done_nxt = 1'b1;
          st_nxt   = CB_IDLE;
        end else begin
          bit_nxt = bit_r - 4'd1;
          st_nxt  = CB_SQ;
        end
      end
      default: st_nxt = CB_IDLE;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.x    = sat_r ? ONE_Q16 : {1'b0, x_r};
endmodule
`default_nettype wire

### rtl/core/sky_model_spline_evaluator_top.sv
// Top level: coefficient memory and the evaluate sequencer of the sky model spline.
// Load beat: written to the coefficient RAM at the accepting edge, no result.
// Evaluate beat: out_tvalid rises after the bit-serial cube root (skipped when the elevation is
// at or above half pi), 24 serial RAM reads (12 at the top turbidity index) and the blends.
// One item at a time; a new beat is taken while a finished result waits. Reset clears control
// and bank select, not RAM.
`default_nettype none
`include "sky_model_spline_evaluator_top_macros.svh"
module sky_model_spline_evaluator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [12:0] load_address, [44:13] load_value, [46:45] channel, [50:47] param_index,
  // [66:51] turbidity, [83:67] albedo, [99:84] sun_elev, [103:100] zero
  input  logic [smse_pkg::IN_W-1:0]   in_tdata,
  // [0] req_type
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [31:0] coefficient
  output logic [smse_pkg::OUT_W-1:0]  out_tdata,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata
);
  import smse_pkg::*;

  // input fields
  logic [12:0] f_addr;
  logic [31:0] f_value;
  logic [1:0]  f_chan;
  logic [3:0]  f_row;
  logic [15:0] f_turb;
  logic [16:0] f_alb;
  logic [15:0] f_elev;

  assign f_addr  = in_tdata[12:0];
  assign f_value = in_tdata[44:13];
  assign f_chan  = in_tdata[46:45];
  assign f_row   = in_tdata[50:47];
  assign f_turb  = in_tdata[66:51];
  assign f_alb   = in_tdata[83:67];
  assign f_elev  = in_tdata[99:84];

  smse_state_t state_r, state_nxt;

  logic accept, acc_load, acc_eval;
  logic bank_r;

  // latched request
  logic [1:0]               chan_r;
  logic [ROW_W-1:0]         row_r;
  logic [TI_W-1:0]          ti_r;
  logic                     top_r;
  logic signed [TF_W-1:0]   f_r, tf_r, alb_r, wa_r;

  // curve basis
  logic [X_W-1:0]   xv_r, uv_r;
  logic [X_W-1:0]   xs_r [6];
  logic [X_W-1:0]   us_r [6];
  logic [BAS_W-1:0] bs_r [6];
  logic [2:0]       pk_r;
  logic [33:0]      xprod, uprod, bprod;
  logic [BAS_W-1:0] bnew;

  // read / multiply-accumulate pipeline
  logic [2:0]              kk_r;
  logic [1:0]              cn_r, last_cn;
  logic                    issue, issue_end;
  logic                    iss_v_r, iss_last_r, v2_r, last2_r;
  logic [1:0]              iss_cn_r, cn2_r;
  logic [RA_W-1:0]         rd_addr;
  logic                    rd_oob;
  logic signed [31:0]      q_r;
  logic signed [PRD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r, mac_sum, mac_rnd;
  logic signed [CUR_W-1:0] cv_r [4];

  // blends
  logic signed [MP_W-1:0]  pm_r, sum_r;
  logic signed [MP_W:0]    mix_full;
  logic signed [MIX_W-1:0] m0_r, m1_r;
  logic signed [TP_W-1:0]  tp_r, tsum_r;
  logic signed [TP_W:0]    t_full;
  logic signed [49:0]      res;
  logic [31:0]             res_sat;
  logic                    out_free;
  logic                    out_valid_r;
  logic [31:0]             out_data_r;

  // coefficient RAM
  logic [31:0]  mem [TABLE_DEPTH];
  logic [13:0]  wa14;

  smse_cb_req_t cb_req;
  smse_cb_rsp_t cb_rsp;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign acc_load  = accept && (in_tuser == REQ_LOAD);
  assign acc_eval  = accept && (in_tuser == REQ_EVAL);
  assign out_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cb_req.start = acc_eval;
  assign cb_req.elev  = f_elev;

  smse_cbrt u_cbrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cb_req),
    .rsp   (cb_rsp)
  );

  // bank select
  always_ff @(posedge clk) begin
    if (!rst_n) bank_r <= 1'b0;
    else if (cfg_we) bank_r <= cfg_wdata;
  end

  // request capture, with the clamps on channel, row, albedo and turbidity index
  always_ff @(posedge clk) begin
    logic [TI_W-1:0] ti;
    if (acc_eval) begin
      chan_r <= (f_chan > 2'd2) ? 2'd2 : f_chan;
      row_r  <= (int'(f_row) > SHAPE_PARAMS) ? ROW_W'(SHAPE_PARAMS) : ROW_W'(f_row);
      if (f_turb[15:12] < 4'd1) ti = TI_W'(1);
      else if (int'(f_turb[15:12]) > TURB_STEPS) ti = TI_W'(TURB_STEPS);
      else ti = TI_W'(f_turb[15:12]);
      ti_r  <= ti;
      top_r <= (int'(ti) == TURB_STEPS);
      f_r   <= $signed({2'b00, f_turb}) - $signed(TF_W'(ti) << 12);
      tf_r  <= $signed(TF_W'(4096)) - ($signed({2'b00, f_turb}) - $signed(TF_W'(ti) << 12));
      if (f_alb > 17'd65536) begin
        alb_r <= $signed(TF_W'(65536));
        wa_r  <= '0;
      end else begin
        alb_r <= $signed({1'b0, f_alb});
        wa_r  <= $signed(TF_W'(65536)) - $signed({1'b0, f_alb});
      end
    end
  end

  // RAM: one write port for loads, one registered read port for the curves
  assign wa14 = {1'b0, f_addr};

  always_ff @(posedge clk) begin
    if (acc_load && (int'(f_addr) < TABLE_DEPTH)) mem[wa14[ADDR_W-1:0]] <= f_value;
    if (rd_oob) q_r <= '0;
    else q_r <= $signed(mem[rd_addr[ADDR_W-1:0]]);
  end

  // control point address for curve cn_r, point kk_r
  always_comb begin
    int slot, idx, ofs;
    slot = int'(ti_r) - 1 + int'(cn_r[1]);
    idx  = 6 * slot + SET_OFS * int'(cn_r[0]) + int'(kk_r);
    if (int'(row_r) < SHAPE_PARAMS) ofs = idx * SHAPE_PARAMS + int'(row_r);
    else ofs = RAD_OFS + idx;
    rd_addr = RA_W'((int'(bank_r) * 3 + int'(chan_r)) * CH_WORDS + ofs);
    rd_oob  = (int'(rd_addr) >= TABLE_DEPTH);
  end

  assign last_cn   = top_r ? 2'd1 : 2'd3;
  assign issue     = (state_r == ST_MAC);
  assign issue_end = issue && (kk_r == 3'd5) && (cn_r == last_cn);

  // powers of x and u; basis terms
  assign xprod = 34'(xs_r[5]) * 34'(xv_r);
  assign uprod = 34'(us_r[5]) * 34'(uv_r);
  assign bprod = 34'(xs_r[0]) * 34'(us_r[5]);
  assign bnew  = BAS_W'(bprod[32:16]) * BAS_W'(binom5(pk_r));

  assign mac_sum = acc_r + ACC_W'(prod_r);
  assign mac_rnd = mac_sum + ACC_W'(32768);

  assign mix_full = $signed({sum_r[MP_W-1], sum_r}) + $signed({pm_r[MP_W-1], pm_r})
                  + $signed((MP_W + 1)'(32768));
  assign t_full   = $signed({tsum_r[TP_W-1], tsum_r}) + $signed({tp_r[TP_W-1], tp_r})
                  + $signed((TP_W + 1)'(2048));
  assign res      = t_full[61:12];

  always_comb begin
    if ((res[49:31] == '0) || (res[49:31] == '1)) res_sat = res[31:0];
    else if (res[49]) res_sat = 32'h8000_0000;
    else res_sat = 32'h7fff_ffff;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_r        <= '0;
      kk_r        <= '0;
      cn_r        <= '0;
      iss_v_r     <= 1'b0;
      iss_last_r  <= 1'b0;
      v2_r        <= 1'b0;
      last2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      iss_v_r    <= issue;
      iss_last_r <= issue && (kk_r == 3'd5);
      iss_cn_r   <= cn_r;
      v2_r       <= iss_v_r;
      last2_r    <= iss_last_r;
      cn2_r      <= iss_cn_r;

      case (state_r)
        ST_CBRT: begin
          if (cb_rsp.done) begin
            xv_r     <= cb_rsp.x;
            uv_r     <= ONE_Q16 - cb_rsp.x;
            xs_r[5]  <= ONE_Q16;
            us_r[5]  <= ONE_Q16;
            pk_r     <= '0;
          end
        end
        ST_POW: begin
          for (int i = 0; i < 5; i++) begin
            xs_r[i] <= xs_r[i + 1];
            us_r[i] <= us_r[i + 1];
          end
          xs_r[5] <= xprod[32:16];
          us_r[5] <= uprod[32:16];
          pk_r    <= (pk_r == 3'd4) ? 3'd0 : pk_r + 3'd1;
        end
        ST_BAS: begin
          // x powers walk down, u powers walk up: pairs x^k with u^(5-k)
          for (int i = 0; i < 5; i++) begin
            xs_r[i]     <= xs_r[i + 1];
            us_r[i + 1] <= us_r[i];
            bs_r[i]     <= bs_r[i + 1];
          end
          xs_r[5] <= xs_r[0];
          us_r[0] <= us_r[5];
          bs_r[5] <= bnew;
          pk_r    <= pk_r + 3'd1;
          if (pk_r == 3'd5) begin
            kk_r  <= '0;
            cn_r  <= '0;
            acc_r <= '0;
          end
        end
        ST_MAC: begin
          if (kk_r == 3'd5) begin
            kk_r <= '0;
            cn_r <= cn_r + 2'd1;
          end else begin
            kk_r <= kk_r + 3'd1;
          end
        end
        ST_MA0: pm_r <= MP_W'(cv_r[0]) * MP_W'(wa_r);
        ST_MA1: begin
          sum_r <= pm_r;
          pm_r  <= MP_W'(cv_r[1]) * MP_W'(alb_r);
        end
        ST_MA2: begin
          m0_r <= mix_full[MP_W:16];
          pm_r <= MP_W'(cv_r[2]) * MP_W'(wa_r);
        end
        ST_MA3: begin
          sum_r <= pm_r;
          pm_r  <= MP_W'(cv_r[3]) * MP_W'(alb_r);
        end
        ST_MA4: m1_r <= mix_full[MP_W:16];
        ST_TB0: tp_r <= TP_W'(m0_r) * TP_W'(tf_r);
        ST_TB1: begin
          tsum_r <= tp_r;
          // top index blends slot k only
          tp_r   <= top_r ? '0 : TP_W'(m1_r) * TP_W'(f_r);
        end
        default: ;
      endcase

      // read data times basis; the basis line rotates once per point
      if (iss_v_r) begin
        prod_r <= PRD_W'($signed({1'b0, bs_r[0]})) * PRD_W'(q_r);
        for (int i = 0; i < 5; i++) bs_r[i] <= bs_r[i + 1];
        bs_r[5] <= bs_r[0];
      end

      if (v2_r) begin
        if (last2_r) begin
          acc_r        <= '0;
          cv_r[cn2_r]  <= mac_rnd[ACC_W-1:16];
        end else begin
          acc_r <= mac_sum;
        end
      end

      if ((state_r == ST_TB2) && out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_sat;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (acc_eval) state_nxt = ST_CBRT;
      ST_CBRT:  if (cb_rsp.done) state_nxt = ST_POW;
      ST_POW:   if (pk_r == 3'd4) state_nxt = ST_BAS;
      ST_BAS:   if (pk_r == 3'd5) state_nxt = ST_MAC;
      ST_MAC:   if (issue_end) state_nxt = ST_DRAIN;
      ST_DRAIN: if (v2_r && last2_r && (cn2_r == last_cn)) state_nxt = ST_MA0;
      ST_MA0:   state_nxt = ST_MA1;
      ST_MA1:   state_nxt = ST_MA2;
      ST_MA2:   state_nxt = ST_MA3;
      ST_MA3:   state_nxt = ST_MA4;
      ST_MA4:   state_nxt = ST_TB0;
      ST_TB0:   state_nxt = ST_TB1;
      ST_TB1:   state_nxt = ST_TB2;
      ST_TB2:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  `SMSE_ASSERT_SAME(a_idle_pipe_empty, in_tready, !iss_v_r && !v2_r, "read pipe busy in idle")
  `SMSE_ASSERT_SAME(a_cbrt_done_state, cb_rsp.done, state_r == ST_CBRT, "cube root done early")
  `SMSE_ASSERT_NEXT(a_eval_starts, acc_eval, state_r == ST_CBRT, "evaluate beat not started")
  `SMSE_ASSERT_NEXT(a_result_lands, (state_r == ST_TB2) && out_free, out_tvalid, "result lost")
endmodule
`default_nettype wire

### tb/sv/smse_checker.sv
// Checker for the sky model spline evaluator: watches both streams, predicts and compares.
`timescale 1ns / 100ps
module smse_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [smse_pkg::IN_W-1:0]  in_tdata,
  input  logic                       in_tuser,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [smse_pkg::OUT_W-1:0] out_tdata,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  output int                         mismatches,
  output int                         pending
);
  import smse_pkg::*;

  logic [31:0] coef_mem [TABLE_DEPTH];
  logic        bank_sel;
  logic [31:0] coef_queue [$];

  function automatic longint mem_word(longint addr);
    if (addr >= TABLE_DEPTH) return 0;
    return longint'($signed(coef_mem[addr]));
  endfunction

  function automatic longint elev_to_x(longint elev);
    longint r, x, tr;
    if (elev >= HALF_PI_Q14) return 65536;
    r = (elev << 48) / HALF_PI_Q14;
    x = 0;
    for (int b = 15; b >= 0; b--) begin
      tr = x | (longint'(1) << b);
      if (tr * tr * tr <= r) x = tr;
    end
    return x;
  endfunction

  // Bernstein curve for one turbidity slot and one albedo set
  function automatic longint bern_curve(longint basis [6], longint base, longint row,
                                        longint slot, longint set);
    longint acc, idx, addr;
    acc = 0;
    for (int k = 0; k < 6; k++) begin
      idx = 6 * slot + SET_OFS * set + k;
      if (row < SHAPE_PARAMS) addr = base + idx * SHAPE_PARAMS + row;
      else addr = base + RAD_OFS + idx;
      acc += basis[k] * mem_word(addr);
    end
    return (acc + 32768) >>> 16;
  endfunction

  function automatic longint albedo_blend(longint m0, longint m1, longint a);
    return (m0 * (65536 - a) + m1 * a + 32768) >>> 16;
  endfunction

  function automatic logic [31:0] spline_coefficient(logic [IN_W-1:0] d);
    longint chan, row, turb, alb, x, u, ti, f, base, m0, m1, r;
    longint xp [6];
    longint up [6];
    longint basis [6];
    chan = d[46:45];
    if (chan > 2) chan = 2;
    row = d[50:47];
    if (row > SHAPE_PARAMS) row = SHAPE_PARAMS;
    turb = d[66:51];
    alb  = d[83:67];
    if (alb > 65536) alb = 65536;
    x = elev_to_x(longint'(d[99:84]));
    u = 65536 - x;
    xp[0] = 65536;
    up[0] = 65536;
    for (int k = 1; k < 6; k++) begin
      xp[k] = (xp[k-1] * x) >> 16;
      up[k] = (up[k-1] * u) >> 16;
    end
    for (int k = 0; k < 6; k++) basis[k] = binom5(k[2:0]) * ((up[5-k] * xp[k]) >> 16);
    ti = turb >> 12;
    if (ti < 1) ti = 1;
    if (ti > TURB_STEPS) ti = TURB_STEPS;
    f = turb - (ti << 12);
    base = (longint'(bank_sel) * 3 + chan) * CH_WORDS;
    m0 = albedo_blend(bern_curve(basis, base, row, ti - 1, 0),
                      bern_curve(basis, base, row, ti - 1, 1), alb);
    if (ti == TURB_STEPS) begin
      r = (m0 * (4096 - f) + 2048) >>> 12;
    end else begin
      m1 = albedo_blend(bern_curve(basis, base, row, ti, 0),
                        bern_curve(basis, base, row, ti, 1), alb);
      r = (m0 * (4096 - f) + m1 * f + 2048) >>> 12;
    end
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  assign pending = coef_queue.size();

  initial mismatches = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      bank_sel <= 1'b0;
    end else begin
      if (cfg_we) bank_sel <= cfg_wdata;
      if (in_tvalid && in_tready) begin
        if (in_tuser == REQ_LOAD) coef_mem[in_tdata[12:0]] = in_tdata[44:13];
        else coef_queue.push_back(spline_coefficient(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        if (coef_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %h", out_tdata);
        end else begin
          logic [31:0] want;
          want = coef_queue.pop_front();
          if (want !== out_tdata) begin
            mismatches++;
            if (mismatches <= 10)
              $display("coefficient mismatch: expected %h actual %h", want, out_tdata);
          end
        end
      end
    end
  end
endmodule

### tb/sv/tb.sv
// Testbench top: stimulus, flow control and verdict for the sky model spline evaluator.
`timescale 1ns / 100ps
module tb;
  import smse_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 150;  // beyond the evaluate latency
  localparam int HOLD_CYCLES    = 400;  // long receiver hold-off
  localparam logic BANK_RGB = 1'b0;
  localparam logic BANK_XYZ = 1'b1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic                cfg_we = 1'b0;
  logic                cfg_wdata = 1'b0;

  int mismatches, pending;
  int send_idle_pct = 0;   // sender idle odds per cycle
  int recv_stall_pct = 0;  // receiver stall odds per cycle
  logic hold_req = 1'b0;   // ask receiver for one long hold-off
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  logic cur_bank = 1'b0;   // bank select last written

  always #5 clk = ~clk;

  sky_model_spline_evaluator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  smse_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending)
  );

  // Receiver: random stalls per phase, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: cycles with no beat on either stream.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [IN_W-1:0] pack_beat(logic [12:0] addr, logic [31:0] value,
      logic [1:0] chan, logic [3:0] row, logic [15:0] turb, logic [16:0] alb,
      logic [15:0] elev);
    return {4'b0, elev, alb, turb, row, chan, value, addr};
  endfunction

  // Offer one beat and wait for it to be taken; tvalid stays up after the beat.
  task automatic send_beat(logic kind, logic [IN_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic load_word(logic [12:0] addr, logic [31:0] value);
    send_beat(REQ_LOAD, pack_beat(addr, value, 2'($urandom), 4'($urandom), 16'($urandom),
                                  17'($urandom), 16'($urandom)));
  endtask

  task automatic eval_coef(logic [1:0] chan, logic [3:0] row, logic [15:0] turb,
                           logic [16:0] alb, logic [15:0] elev);
    send_beat(REQ_EVAL, pack_beat(13'($urandom), $urandom, chan, row, turb, alb, elev));
  endtask

  // Table words: mostly moderate so blends stay in range, some full-range.
  function automatic logic [31:0] rand_word();
    if ($urandom_range(15) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000);
  endfunction

  // Load every word that one bank, channel and row reads; the two extremes go first.
  task automatic fill_row(logic bank, logic [1:0] chan, logic [3:0] row);
    int addr;
    for (int idx = 0; idx < 12 * TURB_STEPS; idx++) begin
      if (int'(row) < SHAPE_PARAMS) addr = idx * SHAPE_PARAMS + int'(row);
      else addr = RAD_OFS + idx;
      addr = addr + (int'(bank) * 3 + int'(chan)) * CH_WORDS;
      if (idx == 0) load_word(13'(addr), 32'h7FFFFFFF);
      else if (idx == 1) load_word(13'(addr), 32'h80000000);
      else load_word(13'(addr), rand_word());
    end
  endtask

  task automatic random_item();
    int sel;
    logic [1:0] chan;
    logic [3:0] row;
    logic [15:0] turb, elev;
    logic [16:0] alb;
    sel = $urandom_range(99);
    if (sel < 30) begin
      load_word(13'($urandom), rand_word());
    end else begin
      // only filled rows: one shape row and the radiance row per bank
      if ($urandom_range(1) == 0) begin
        chan = (cur_bank == BANK_RGB) ? 2'd0 : 2'd1;
        row  = (cur_bank == BANK_RGB) ? 4'd0 : 4'd4;
      end else begin
        // channel three reads channel two, rows past radiance read radiance
        chan = 2'd2 + 2'($urandom_range(1));
        row  = ($urandom_range(3) == 0) ? 4'($urandom_range(10, 15)) : 4'd9;
      end
      // mostly nominal ranges, occasional full-width fields
      turb = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4096, 40960));
      alb  = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      elev = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 25736));
      eval_coef(chan, row, turb, alb, elev);
    end
  endtask

  // Quiet the sender, let everything drain, then write the bank select.
  task automatic set_bank(logic bank);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= bank;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_bank = bank;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the rows that evaluates use, so none reads an unwritten word.
    fill_row(BANK_RGB, 2'd0, 4'd0);
    fill_row(BANK_RGB, 2'd2, 4'd9);
    fill_row(BANK_XYZ, 2'd1, 4'd4);
    fill_row(BANK_XYZ, 2'd2, 4'd9);

    // Directed: field extremes and open cases.
    set_bank(BANK_RGB);
    eval_coef(2'd0, 4'd0, 16'd4096, 17'd0, 16'd0);          // elevation zero
    eval_coef(2'd0, 4'd0, 16'd4096, 17'd65536, 16'd0);      // full albedo
    eval_coef(2'd2, 4'd9, 16'd8192, 17'd32768, 16'd25735);  // just below half pi
    eval_coef(2'd2, 4'd9, 16'd12000, 17'd1000, 16'd25736);  // exactly half pi
    eval_coef(2'd0, 4'd0, 16'd20000, 17'd40000, 16'hFFFF);  // clamped elevation
    eval_coef(2'd3, 4'd9, 16'd16384, 17'd500, 16'd100);     // channel three
    eval_coef(2'd2, 4'd15, 16'd30000, 17'd60000, 16'd9000); // row past radiance
    eval_coef(2'd3, 4'd10, 16'd5000, 17'd10, 16'd1);
    eval_coef(2'd0, 4'd0, 16'd40960, 17'd20000, 16'd12000); // top turbidity index
    eval_coef(2'd2, 4'd9, 16'd38000, 17'd20000, 16'd12000); // just below top index
    eval_coef(2'd0, 4'd0, 16'hFFFF, 17'd30000, 16'd3000);   // turbidity above range
    eval_coef(2'd2, 4'd9, 16'd0, 17'd30000, 16'd3000);      // turbidity below range
    eval_coef(2'd0, 4'd0, 16'd100, 17'h1FFFF, 16'd20000);   // albedo above one
    eval_coef(2'd3, 4'd12, 16'd24576, 17'd65537, 16'd7);
    load_word(13'h1FFF, 32'h7FFFFFFF);
    load_word(13'h0AAA, 32'h80000000);
    eval_coef(2'd0, 4'd0, 16'd4096, 17'd0, 16'd25000);
    set_bank(BANK_XYZ);
    eval_coef(2'd2, 4'd9, 16'd40960, 17'd65536, 16'd25736);
    eval_coef(2'd1, 4'd4, 16'd4096, 17'd0, 16'd0);
    eval_coef(2'd3, 4'd15, 16'hFFFF, 17'h1FFFF, 16'hFFFF);

    // Random phases: no idling, sender gaps, receiver stalls, both.
    for (int ph = 0; ph < 4; ph++) begin
      set_bank(ph[0] ? BANK_RGB : BANK_XYZ);
      for (int i = 0; i < 275; i++) begin
        // a short stretch without idling inside the idle phases
        if (ph != 0 && (i % 100) >= 50 && (i % 100) < 60) begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end else begin
          send_idle_pct  = (ph == 1) ? 68 : (ph == 3) ? 17 : 0;
          recv_stall_pct = (ph == 2) ? 68 : (ph == 3) ? 17 : 0;
        end
        if (ph == 0 && i == 100) hold_req <= 1'b1;  // sender keeps offering meanwhile
        random_item();
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_bank(BANK_RGB);
    for (int i = 0; i < 20; i++) random_item();
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
